// ----- hdl/hkv_pkg.sv -----
// Shared constants, codes and control types for the hash key-value table.
`timescale 1ns / 1ps

package hkv_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int WAYS = 8;
  localparam int TOTAL_SLOTS = NUM_BUCKETS * WAYS;
  localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  localparam logic [31:0] DJB_START = 32'd5381;

  localparam logic CFG_KEY_MODE = 1'b0;
  localparam logic CFG_KEY_BYTES = 1'b1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_BUCKET,
    S_ROW,
    S_RD,
    S_CMP,
    S_ACT,
    S_CLR
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic calc_bucket;
    logic read_row;
    logic read_way;
    logic cmp_way;
    logic next_way;
    logic clear_step;
    logic act;
  } ctl_cmd_t;

  typedef struct packed {
    logic djb_mode;
    logic hash_last;
    logic match;
    logic last_way;
    logic clear_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- hdl/hkv_datapath.sv -----
// Datapath: configuration, hashing, bucket memories, scan and output register.
`timescale 1ns / 1ps

module hkv_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic [1:0]          req_type,
  input  logic [63:0]         key,
  input  logic [31:0]         value,
  input  hkv_pkg::ctl_cmd_t   cmd,
  output hkv_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic                hit,
  output logic [31:0]         found_value,
  output logic [11:0]         entry_count,
  output logic                table_empty
);

  logic                           key_mode;
  logic [3:0]                     key_bytes;
  hkv_pkg::req_t                  req_r;
  logic [63:0]                    key_r;
  logic [31:0]                    value_r;
  logic [31:0]                    hash;
  logic [2:0]                     byte_idx;
  logic [hkv_pkg::BUCKET_W-1:0]   bucket;
  logic [hkv_pkg::WAY_W-1:0]      way;
  logic [hkv_pkg::WAYS-1:0]       row;
  logic [63:0]                    kdata;
  logic [31:0]                    vdata;
  logic                           hit_r;
  logic [hkv_pkg::WAY_W-1:0]      hit_way;
  logic [31:0]                    found_r;
  logic [11:0]                    count;
  logic [hkv_pkg::BUCKET_W-1:0]   clr_addr;

  logic [hkv_pkg::WAYS-1:0]       valid_mem [hkv_pkg::NUM_BUCKETS];
  logic [63:0]                    key_mem [hkv_pkg::TOTAL_SLOTS];
  logic [31:0]                    value_mem [hkv_pkg::TOTAL_SLOTS];

  logic [3:0]                     nb;
  logic [63:0]                    mask;
  logic [7:0]                     key_byte;
  logic [31:0]                    prod;
  logic [hkv_pkg::SLOT_W-1:0]     base;
  logic [hkv_pkg::SLOT_W-1:0]     way_slot;
  logic                           free_found;
  logic [hkv_pkg::WAY_W-1:0]      free_way;
  logic                           match;

  logic                           v_we;
  logic [hkv_pkg::BUCKET_W-1:0]   v_addr;
  logic [hkv_pkg::WAYS-1:0]       v_wdata;
  logic                           k_we;
  logic                           val_we;
  logic [hkv_pkg::SLOT_W-1:0]     wr_slot;
  hkv_pkg::status_t               res_status;
  logic                           res_hit;
  logic [31:0]                    res_found;
  logic [11:0]                    count_next;
  hkv_pkg::status_t               status_r;

  always_comb begin
    if (key_bytes == 4'd0) begin
      nb = 4'd1;
    end else if (key_bytes > 4'd8) begin
      nb = 4'd8;
    end else begin
      nb = key_bytes;
    end
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (!key_mode || (4'(b) < nb)) ? 8'hFF : 8'h00;
    end
  end

  assign key_byte = key_r[{byte_idx, 3'b000} +: 8];
  assign prod = hash + {hash[30:0], 1'b0} + {hash[28:0], 3'b000};
  assign base = hkv_pkg::SLOT_W'(int'(bucket) * hkv_pkg::WAYS);
  assign way_slot = base + hkv_pkg::SLOT_W'(way);
  assign match = row[way] && (((kdata ^ key_r) & mask) == 64'd0);

  always_comb begin
    free_found = 1'b0;
    free_way = '0;
    for (int w = hkv_pkg::WAYS - 1; w >= 0; w--) begin
      if (!row[w]) begin
        free_found = 1'b1;
        free_way = hkv_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    v_we = cmd.clear_step;
    v_addr = clr_addr;
    v_wdata = '0;
    k_we = 1'b0;
    val_we = 1'b0;
    wr_slot = base + hkv_pkg::SLOT_W'(hit_way);
    res_status = hkv_pkg::ST_NOT_FOUND;
    res_hit = 1'b0;
    res_found = 32'd0;
    count_next = count;
    if (cmd.act) begin
      unique case (req_r)
        hkv_pkg::REQ_INSERT: begin
          if (hit_r) begin
            val_we = 1'b1;
            res_status = hkv_pkg::ST_UPDATED;
            res_hit = 1'b1;
          end else if (free_found) begin
            v_we = 1'b1;
            v_addr = bucket;
            v_wdata = row | (hkv_pkg::WAYS'(1) << free_way);
            k_we = 1'b1;
            val_we = 1'b1;
            wr_slot = base + hkv_pkg::SLOT_W'(free_way);
            count_next = count + 12'd1;
            res_status = hkv_pkg::ST_INSERTED;
          end else begin
            res_status = hkv_pkg::ST_FULL;
          end
        end
        hkv_pkg::REQ_LOOKUP: begin
          if (hit_r) begin
            res_status = hkv_pkg::ST_FOUND;
            res_hit = 1'b1;
            res_found = found_r;
          end
        end
        hkv_pkg::REQ_REMOVE: begin
          if (hit_r) begin
            v_we = 1'b1;
            v_addr = bucket;
            v_wdata = row & ~(hkv_pkg::WAYS'(1) << hit_way);
            if (count != 12'd0) begin
              count_next = count - 12'd1;
            end
            res_status = hkv_pkg::ST_REMOVED;
            res_hit = 1'b1;
          end
        end
        hkv_pkg::REQ_CLEAR: begin
          count_next = 12'd0;
          res_status = hkv_pkg::ST_CLEARED;
        end
        default: begin
          res_status = hkv_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= 1'b0;
      key_bytes <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hkv_pkg::CFG_KEY_MODE:  key_mode <= cfg_data[0];
        hkv_pkg::CFG_KEY_BYTES: key_bytes <= cfg_data;
        default:                key_mode <= key_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
      way <= '0;
      hit_r <= 1'b0;
      count <= 12'd0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        byte_idx <= '0;
        hit_r <= 1'b0;
        clr_addr <= '0;
      end
      if (cmd.hash_step) begin
        byte_idx <= byte_idx + 3'd1;
      end
      if (cmd.calc_bucket) begin
        way <= '0;
      end
      if (cmd.next_way) begin
        way <= way + hkv_pkg::WAY_W'(1);
      end
      if (cmd.cmp_way && match) begin
        hit_r <= 1'b1;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + hkv_pkg::BUCKET_W'(1);
        count <= 12'd0;
      end
      if (cmd.act) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= hkv_pkg::req_t'(req_type);
      key_r <= key;
      value_r <= value;
      hash <= key_mode ? hkv_pkg::DJB_START : key[31:0];
    end
    if (cmd.hash_step) begin
      hash <= {hash[26:0], 5'b00000} + hash + {24'd0, key_byte};
    end
    if (cmd.calc_bucket) begin
      bucket <= hkv_pkg::BUCKET_W'(prod % hkv_pkg::NUM_BUCKETS);
    end
    if (cmd.cmp_way && match) begin
      hit_way <= way;
      found_r <= vdata;
    end
    if (cmd.act) begin
      status_r <= res_status;
      hit <= res_hit;
      found_value <= res_found;
      entry_count <= count_next;
      table_empty <= (count_next == 12'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      valid_mem[v_addr] <= v_wdata;
    end
    if (cmd.read_row) begin
      row <= valid_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      key_mem[wr_slot] <= key_r;
    end
    if (cmd.read_way) begin
      kdata <= key_mem[way_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[wr_slot] <= value_r;
    end
    if (cmd.read_way) begin
      vdata <= value_mem[way_slot];
    end
  end

  assign status = status_r;

  assign stat.djb_mode = key_mode;
  assign stat.hash_last = ({1'b0, byte_idx} == (nb - 4'd1));
  assign stat.match = match;
  assign stat.last_way = (way == hkv_pkg::WAY_W'(hkv_pkg::WAYS - 1));
  assign stat.clear_last = (clr_addr == hkv_pkg::BUCKET_W'(hkv_pkg::NUM_BUCKETS - 1));
  assign stat.out_busy = out_valid && out_stall;

endmodule

// ----- hdl/hkv_controller.sv -----
// Controller state machine that sequences hashing, bucket scan, commit and clearing.
`timescale 1ns / 1ps

module hkv_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         req_type,
  input  hkv_pkg::dp_stat_t  stat,
  output logic               in_stall,
  output hkv_pkg::ctl_cmd_t  cmd
);

  hkv_pkg::state_t state;
  hkv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkv_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      hkv_pkg::S_INIT: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = hkv_pkg::S_IDLE;
        end
      end
      hkv_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (req_type == hkv_pkg::REQ_CLEAR) begin
            state_next = hkv_pkg::S_CLR;
          end else if (stat.djb_mode) begin
            state_next = hkv_pkg::S_HASH;
          end else begin
            state_next = hkv_pkg::S_BUCKET;
          end
        end
      end
      hkv_pkg::S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) begin
          state_next = hkv_pkg::S_BUCKET;
        end
      end
      hkv_pkg::S_BUCKET: begin
        cmd.calc_bucket = 1'b1;
        state_next = hkv_pkg::S_ROW;
      end
      hkv_pkg::S_ROW: begin
        cmd.read_row = 1'b1;
        state_next = hkv_pkg::S_RD;
      end
      hkv_pkg::S_RD: begin
        cmd.read_way = 1'b1;
        state_next = hkv_pkg::S_CMP;
      end
      hkv_pkg::S_CMP: begin
        cmd.cmp_way = 1'b1;
        if (stat.match || stat.last_way) begin
          state_next = hkv_pkg::S_ACT;
        end else begin
          cmd.next_way = 1'b1;
          state_next = hkv_pkg::S_RD;
        end
      end
      hkv_pkg::S_ACT: begin
        if (!stat.out_busy) begin
          cmd.act = 1'b1;
          state_next = hkv_pkg::S_IDLE;
        end
      end
      hkv_pkg::S_CLR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = hkv_pkg::S_ACT;
        end
      end
      default: begin
        state_next = hkv_pkg::S_INIT;
      end
    endcase
  end

endmodule

// ----- hdl/hash_key_value_table.sv -----
// Top level of the hash key-value table: controller, datapath and checks.
//
//   channel  direction  handshake             fields
//   request  in         in_valid / in_stall   req_type, key, value
//   result   out        out_valid / out_stall status, hit, found_value,
//                                             entry_count, table_empty
//   config   in         cfg_we                cfg_index, cfg_data
//
// A lookup, insert or remove is accepted, hashed one key byte at a time in djb2
// mode (1 to 8 bytes, key_bytes held to that range), then the bucket is formed
// and its valid row read, the ways (up to WAYS) are scanned in turn and it commits.
// A clear sweeps the valid-row memory, one bucket a cycle.
// After reset the same sweep runs before the first word is accepted.
// A new word is taken while the previous result waits; the commit waits for it.
`timescale 1ns / 1ps

module hash_key_value_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        hit,
  output logic [31:0] found_value,
  output logic [11:0] entry_count,
  output logic        table_empty
);

  hkv_pkg::ctl_cmd_t cmd;
  hkv_pkg::dp_stat_t stat;

  hkv_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hkv_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .found_value (found_value),
    .entry_count (entry_count),
    .table_empty (table_empty)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while a request was still in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (table_empty == (entry_count == 12'd0)))
    else $error("table_empty disagrees with entry_count");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hkv_pkg::ST_CLEARED) |-> (entry_count == 12'd0) && !hit)
    else $error("clear result with nonzero count or hit");

endmodule

// ----- tb/sv/tb_hash_key_value_table.sv -----
// Self-checking testbench for the hash key-value table with a built-in table predictor.
`timescale 1ns / 1ps

module tb_hash_key_value_table;

  typedef struct {
    hkv_pkg::status_t st;
    logic             hit;
    logic [31:0]      fval;
    logic [11:0]      cnt;
    logic             empty;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic        hit;
  logic [31:0] found_value;
  logic [11:0] entry_count;
  logic        table_empty;

  hash_key_value_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .key(key),
    .value(value), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .hit(hit), .found_value(found_value), .entry_count(entry_count),
    .table_empty(table_empty)
  );

  logic        mdl_mode;
  logic [3:0]  mdl_bytes;
  logic        mdl_valid [hkv_pkg::TOTAL_SLOTS];
  logic [63:0] mdl_key [hkv_pkg::TOTAL_SLOTS];
  logic [31:0] mdl_val [hkv_pkg::TOTAL_SLOTS];
  logic [11:0] mdl_count;

  reply_t      pending_replies[$];
  int          errors;
  int          cycles;
  int          stall_left;
  logic [63:0] used_keys[$];

  localparam int CYCLE_LIMIT = 3000000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int key_len();
    if (mdl_bytes < 4'd1) return 1;
    if (mdl_bytes > 4'd8) return 8;
    return int'(mdl_bytes);
  endfunction

  function automatic logic [63:0] key_mask();
    if (!mdl_mode || key_len() == 8) return '1;
    return (64'd1 << (key_len() * 8)) - 64'd1;
  endfunction

  function automatic int bucket_base(logic [63:0] k);
    logic [31:0] h;
    if (!mdl_mode) h = k[31:0];
    else begin
      h = hkv_pkg::DJB_START;
      for (int i = 0; i < key_len(); i++) h = h * 32'd33 + {24'd0, k[i*8 +: 8]};
    end
    h = h * 32'd11;
    return int'(h % 32'(hkv_pkg::NUM_BUCKETS)) * hkv_pkg::WAYS;
  endfunction

  function automatic reply_t predict_request(hkv_pkg::req_t rq, logic [63:0] k,
                                             logic [31:0] v);
    reply_t r;
    int base;
    int s;
    r.st = hkv_pkg::ST_NOT_FOUND;
    r.hit = 1'b0;
    r.fval = '0;
    if (rq == hkv_pkg::REQ_CLEAR) begin
      foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
      mdl_count = '0;
      r.st = hkv_pkg::ST_CLEARED;
    end else begin
      base = bucket_base(k);
      s = -1;
      for (int w = 0; w < hkv_pkg::WAYS; w++)
        if (s < 0 && mdl_valid[base+w] && ((mdl_key[base+w] ^ k) & key_mask()) == 0)
          s = base + w;
      if (rq == hkv_pkg::REQ_INSERT) begin
        if (s >= 0) begin
          mdl_val[s] = v;
          r.st = hkv_pkg::ST_UPDATED;
          r.hit = 1'b1;
        end else begin
          r.st = hkv_pkg::ST_FULL;
          for (int w = 0; w < hkv_pkg::WAYS; w++)
            if (r.st == hkv_pkg::ST_FULL && !mdl_valid[base+w]) begin
              mdl_valid[base+w] = 1'b1;
              mdl_key[base+w] = k;
              mdl_val[base+w] = v;
              mdl_count++;
              r.st = hkv_pkg::ST_INSERTED;
            end
        end
      end else if (s >= 0) begin
        r.hit = 1'b1;
        if (rq == hkv_pkg::REQ_LOOKUP) begin
          r.st = hkv_pkg::ST_FOUND;
          r.fval = mdl_val[s];
        end else begin
          mdl_valid[s] = 1'b0;
          if (mdl_count > 0) mdl_count--;
          r.st = hkv_pkg::ST_REMOVED;
        end
      end
    end
    r.cnt = mdl_count;
    r.empty = (mdl_count == 0);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
      else stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: status %0d", status);
      end else begin
        e = pending_replies.pop_front();
        if (status !== e.st || hit !== e.hit || found_value !== e.fval ||
            entry_count !== e.cnt || table_empty !== e.empty) begin
          errors++;
          if (errors <= 10)
            $display({"Mismatch: exp st %0d hit %0d val %h cnt %0d emp %0d, ",
                      "got %0d %0d %h %0d %0d"},
                     e.st, e.hit, e.fval, e.cnt, e.empty,
                     status, hit, found_value, entry_count, table_empty);
        end
      end
    end
  end

  task automatic send_request(hkv_pkg::req_t rq, logic [63:0] k, logic [31:0] v);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= rq;
    key <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(predict_request(rq, k, v));
    if (used_keys.size() < 64) used_keys.push_back(k);
    else used_keys[$urandom_range(0, 63)] = k;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [3:0] d);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (hkv_pkg::NUM_BUCKETS + 40) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == hkv_pkg::CFG_KEY_MODE) mdl_mode = d[0];
    else mdl_bytes = d;
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (used_keys.size() != 0 && $urandom_range(0, 99) < 55)
      k = used_keys[$urandom_range(0, used_keys.size() - 1)];
    // Crowd a few buckets so that full buckets occur.
    if ($urandom_range(0, 3) == 0)
      k[31:0] = {24'($urandom_range(0, 3)), 8'h00} ^ {k[7:0], 24'h0};
    return k;
  endfunction

  function automatic hkv_pkg::req_t rand_req();
    int p;
    p = $urandom_range(0, 199);
    if (p < 90) return hkv_pkg::REQ_INSERT;
    if (p < 150) return hkv_pkg::REQ_LOOKUP;
    if (p < 198) return hkv_pkg::REQ_REMOVE;
    return hkv_pkg::REQ_CLEAR;
  endfunction

  task automatic test_directed();
    send_request(hkv_pkg::REQ_LOOKUP, 64'd0, 32'hFFFF_FFFF);
    send_request(hkv_pkg::REQ_REMOVE, 64'd0, 32'd0);
    send_request(hkv_pkg::REQ_INSERT, 64'd0, 32'd0);
    send_request(hkv_pkg::REQ_INSERT, '1, 32'hFFFF_FFFF);
    send_request(hkv_pkg::REQ_INSERT, 64'd0, 32'h1234_5678);
    send_request(hkv_pkg::REQ_LOOKUP, 64'd0, 32'd0);
    send_request(hkv_pkg::REQ_LOOKUP, '1, 32'd0);
    // Same low word fills one bucket and then overflows it.
    for (int i = 0; i < hkv_pkg::WAYS + 2; i++)
      send_request(hkv_pkg::REQ_INSERT, {32'(i + 1), 32'h0000_0100}, 32'(i));
    send_request(hkv_pkg::REQ_REMOVE, {32'd3, 32'h0000_0100}, 32'd0);
    send_request(hkv_pkg::REQ_INSERT, {32'd77, 32'h0000_0100}, 32'hAA);
    send_request(hkv_pkg::REQ_LOOKUP, {32'd77, 32'h0000_0100}, 32'd0);
    send_request(hkv_pkg::REQ_REMOVE, '1, 32'd0);
    send_request(hkv_pkg::REQ_CLEAR, '1, 32'hFFFF_FFFF);
    send_request(hkv_pkg::REQ_LOOKUP, 64'd0, 32'd0);
  endtask

  task automatic test_modes();
    logic [3:0] sets[6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
    foreach (sets[j]) begin
      write_reg(hkv_pkg::CFG_KEY_MODE, {3'b000, j[0] | (j > 1)});
      write_reg(hkv_pkg::CFG_KEY_BYTES, sets[j]);
      repeat (230) send_request(rand_req(), rand_key(), $urandom);
    end
  endtask

  task automatic test_random();
    write_reg(hkv_pkg::CFG_KEY_MODE, 4'd1);
    write_reg(hkv_pkg::CFG_KEY_BYTES, 4'd2);
    repeat (200) send_request(rand_req(), rand_key(), $urandom);
    write_reg(hkv_pkg::CFG_KEY_MODE, 4'd0);
    write_reg(hkv_pkg::CFG_KEY_BYTES, 4'd8);
    repeat (250) send_request(rand_req(), rand_key(), $urandom);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = '0;
    key = '0;
    value = '0;
    errors = 0;
    mdl_mode = 1'b0;
    mdl_bytes = 4'd8;
    mdl_count = '0;
    foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_modes();
    test_random();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (hkv_pkg::NUM_BUCKETS + 40) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
